@@ hw/rtl/splitmix_lattice_random_walk_core_macros.svh @@
// assertion macros for the lattice random walk core checker
// no dependencies; taken in by the checker file
`ifndef SPLITMIX_LATTICE_RANDOM_WALK_CORE_MACROS_SVH
`define SPLITMIX_LATTICE_RANDOM_WALK_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SLRW_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slrw check failed");

// consequent checked in the cycle after the antecedent
`define SLRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slrw check failed");

`endif

@@ hw/rtl/slrw_pkg.sv @@
// shared types, constants and helpers of the lattice random walk core
// no dependencies
package slrw_pkg;

  // default configuration of the core
  localparam int MAX_WALK_DEF    = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  // field widths
  localparam int COORD_W   = 32;
  localparam int SEED_W    = 64;
  localparam int WLEN_W    = 7;
  localparam int STEP_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // generator constants
  localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

  // reset values of the configuration registers
  localparam logic [31:0]       MIN_HEIGHT_RST  = 32'sd0;
  localparam logic [31:0]       MAX_HEIGHT_RST  = 32'sd255;
  localparam logic [WLEN_W-1:0] WALK_LENGTH_RST = 7'd8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_HEIGHT  = 2'd0,
    CFG_MAX_HEIGHT  = 2'd1,
    CFG_WALK_LENGTH = 2'd2
  } cfg_reg_e;

  // unit moves, in the order of the mixed value modulo 6
  typedef enum logic [2:0] {
    MOVE_XP = 3'd0,
    MOVE_XN = 3'd1,
    MOVE_YP = 3'd2,
    MOVE_YN = 3'd3,
    MOVE_ZP = 3'd4,
    MOVE_ZN = 3'd5
  } move_e;

  // classified request travelling from front to walker
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [SEED_W-1:0]         seed;
    logic [WLEN_W-1:0]         len;
    logic                      skip;
  } walk_req_t;

  // rebuild a residue mod 6 from its residues mod 2 and mod 3
  function automatic move_e move_from_residues(input logic par, input logic [1:0] r3);
    move_e mv;
    mv = MOVE_XP;
    case ({par, r3})
      3'b0_00: mv = MOVE_XP;
      3'b0_01: mv = MOVE_ZP;
      3'b0_10: mv = MOVE_YP;
      3'b1_00: mv = MOVE_YN;
      3'b1_01: mv = MOVE_XN;
      3'b1_10: mv = MOVE_ZN;
      default: mv = MOVE_XP;
    endcase
    return mv;
  endfunction

endpackage

@@ hw/rtl/slrw_fifo.sv @@
// short request queue between the front and the walker
// depends on slrw_pkg for the request type
module slrw_fifo #(
  parameter int DEPTH = slrw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  slrw_pkg::walk_req_t  wdata_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output slrw_pkg::walk_req_t  rdata_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  slrw_pkg::walk_req_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  // pointer wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // storage write, no reset on payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

endmodule

@@ hw/rtl/slrw_front.sv @@
// front end: configuration registers, request intake and classification
// depends on slrw_pkg
module slrw_front #(
  parameter int MAX_WALK = slrw_pkg::MAX_WALK_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [slrw_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [slrw_pkg::CFG_DAT_W-1:0]         cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [slrw_pkg::COORD_W-1:0]    origin_x_i,
  input  logic signed [slrw_pkg::COORD_W-1:0]    origin_y_i,
  input  logic signed [slrw_pkg::COORD_W-1:0]    origin_z_i,
  input  logic [slrw_pkg::SEED_W-1:0]            walk_seed_i,
  input  logic                                   q_full_i,
  output logic                                   push_o,
  output slrw_pkg::walk_req_t                    req_o
);

  localparam logic [slrw_pkg::WLEN_W-1:0] MAX_LEN = slrw_pkg::WLEN_W'(MAX_WALK);

  logic signed [slrw_pkg::COORD_W-1:0] min_height_q;
  logic signed [slrw_pkg::COORD_W-1:0] max_height_q;
  logic [slrw_pkg::WLEN_W-1:0]         walk_length_q;
  logic [slrw_pkg::WLEN_W-1:0]         len_sat;
  logic                                out_of_range;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_height_q  <= slrw_pkg::MIN_HEIGHT_RST;
      max_height_q  <= slrw_pkg::MAX_HEIGHT_RST;
      walk_length_q <= slrw_pkg::WALK_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        slrw_pkg::CFG_MIN_HEIGHT:  min_height_q  <= cfg_wdata_i;
        slrw_pkg::CFG_MAX_HEIGHT:  max_height_q  <= cfg_wdata_i;
        slrw_pkg::CFG_WALK_LENGTH: walk_length_q <= cfg_wdata_i[slrw_pkg::WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // height window check and length clamp
  always_comb begin
    out_of_range = (origin_y_i < min_height_q) || (max_height_q < origin_y_i);
    len_sat      = (walk_length_q > MAX_LEN) ? MAX_LEN : walk_length_q;
  end

  // classified request into the queue
  always_comb begin
    req_o.x    = origin_x_i;
    req_o.y    = origin_y_i;
    req_o.z    = origin_z_i;
    req_o.seed = walk_seed_i;
    req_o.len  = len_sat;
    req_o.skip = out_of_range || (len_sat == '0);
  end

  assign push_o     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

endmodule

@@ hw/rtl/slrw_walker.sv @@
// back end: walk sequencer with the shared mixer datapath and output register
// depends on slrw_pkg
module slrw_walker #(
  parameter int MAX_WALK = slrw_pkg::MAX_WALK_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  input  slrw_pkg::walk_req_t                   req_i,
  output logic                                  q_pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [slrw_pkg::COORD_W-1:0]   pos_x_o,
  output logic signed [slrw_pkg::COORD_W-1:0]   pos_y_o,
  output logic signed [slrw_pkg::COORD_W-1:0]   pos_z_o,
  output logic [slrw_pkg::STEP_W-1:0]           step_index_o,
  output logic                                  skipped_o,
  output logic                                  last_o
);

  localparam int CNT_W = $clog2(MAX_WALK + 1);
  localparam int IDX_W = (MAX_WALK > 1) ? $clog2(MAX_WALK) : 1;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_EMIT = 9'b000000010,
    ST_ADV  = 9'b000000100,
    ST_MUL1 = 9'b000001000,
    ST_SUM1 = 9'b000010000,
    ST_MUL2 = 9'b000100000,
    ST_SUM2 = 9'b001000000,
    ST_MOD1 = 9'b010000000,
    ST_MOD2 = 9'b100000000
  } walk_state_e;

  walk_state_e state_q, state_d;

  logic signed [slrw_pkg::COORD_W-1:0] cur_x_q, cur_x_d;
  logic signed [slrw_pkg::COORD_W-1:0] cur_y_q, cur_y_d;
  logic signed [slrw_pkg::COORD_W-1:0] cur_z_q, cur_z_d;
  logic [63:0]      gen_q, gen_d;
  logic [63:0]      v_q, v_d;
  logic [63:0]      pp_ll_q;
  logic [31:0]      pp_lh_q, pp_hl_q;
  logic [17:0]      fold_q, fold_d;
  logic             par_q, par_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic             skip_q, skip_d;

  logic                                out_valid_q, out_valid_d;
  logic                                out_load;
  logic signed [slrw_pkg::COORD_W-1:0] out_x_q, out_y_q, out_z_q;
  logic [slrw_pkg::STEP_W-1:0]         out_step_q;
  logic                                out_skip_q, out_last_q;

  logic        out_free;
  logic        is_last;
  logic        fin;
  logic [63:0] gen_adv;
  logic [63:0] mul_k;
  logic [63:0] prod_ll;
  logic [31:0] prod_lh, prod_hl;
  logic [63:0] prod_sum;
  logic [9:0]  f1;
  logic [5:0]  f2;
  logic [3:0]  f3;
  logic [2:0]  f4;
  logic [1:0]  r3;
  slrw_pkg::move_e mv;

  // partial products of the low 64 bits of a 64x64 multiply
  assign mul_k    = (state_q == ST_MUL2) ? slrw_pkg::MIX_MUL_B : slrw_pkg::MIX_MUL_A;
  assign prod_ll  = 64'(v_q[31:0]) * 64'(mul_k[31:0]);
  assign prod_lh  = v_q[31:0] * mul_k[63:32];
  assign prod_hl  = v_q[63:32] * mul_k[31:0];
  assign prod_sum = pp_ll_q + {pp_lh_q + pp_hl_q, 32'h0};

  assign gen_adv = gen_q + slrw_pkg::GOLDEN_INC;

  // residue mod 3 of the mixed value, folded down from 16-bit chunk sum
  always_comb begin
    f1 = 10'(fold_q[7:0]) + 10'(fold_q[15:8]) + 10'(fold_q[17:16]);
    f2 = 6'(f1[3:0]) + 6'(f1[7:4]) + 6'(f1[9:8]);
    f3 = 4'(f2[1:0]) + 4'(f2[3:2]) + 4'(f2[5:4]);
    f4 = 3'(f3[1:0]) + 3'(f3[3:2]);
    r3 = (f4 >= 3'd3) ? 2'(f4 - 3'd3) : f4[1:0];
    mv = slrw_pkg::move_from_residues(par_q, r3);
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_last  = ((CNT_W'(step_q) + CNT_W'(1)) == len_q);
  assign fin      = skip_q || is_last;

  // sequencer
  always_comb begin
    state_d  = state_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    cur_z_d  = cur_z_q;
    gen_d    = gen_q;
    v_d      = v_q;
    fold_d   = fold_q;
    par_d    = par_q;
    len_d    = len_q;
    step_d   = step_q;
    skip_d   = skip_q;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_x_d = req_i.x;
          cur_y_d = req_i.y;
          cur_z_d = req_i.z;
          gen_d   = req_i.seed;
          len_d   = CNT_W'(req_i.len);
          skip_d  = req_i.skip;
          step_d  = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = fin ? ST_IDLE : ST_ADV;
        end
      end
      ST_ADV: begin
        gen_d   = gen_adv;
        v_d     = gen_adv ^ (gen_adv >> 30);
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        state_d = ST_SUM1;
      end
      ST_SUM1: begin
        v_d     = prod_sum ^ (prod_sum >> 27);
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        state_d = ST_SUM2;
      end
      ST_SUM2: begin
        v_d     = prod_sum ^ (prod_sum >> 31);
        state_d = ST_MOD1;
      end
      ST_MOD1: begin
        fold_d  = 18'(v_q[15:0]) + 18'(v_q[31:16]) + 18'(v_q[47:32]) + 18'(v_q[63:48]);
        par_d   = v_q[0];
        state_d = ST_MOD2;
      end
      ST_MOD2: begin
        case (mv)
          slrw_pkg::MOVE_XP: cur_x_d = cur_x_q + 32'sd1;
          slrw_pkg::MOVE_XN: cur_x_d = cur_x_q - 32'sd1;
          slrw_pkg::MOVE_YP: cur_y_d = cur_y_q + 32'sd1;
          slrw_pkg::MOVE_YN: cur_y_d = cur_y_q - 32'sd1;
          slrw_pkg::MOVE_ZP: cur_z_d = cur_z_q + 32'sd1;
          default:           cur_z_d = cur_z_q - 32'sd1;
        endcase
        step_d  = step_q + IDX_W'(1);
        state_d = ST_EMIT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // walk datapath registers
  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    cur_z_q <= cur_z_d;
    gen_q   <= gen_d;
    v_q     <= v_d;
    fold_q  <= fold_d;
    par_q   <= par_d;
    len_q   <= len_d;
    step_q  <= step_d;
    skip_q  <= skip_d;
    if ((state_q == ST_MUL1) || (state_q == ST_MUL2)) begin
      pp_ll_q <= prod_ll;
      pp_lh_q <= prod_lh;
      pp_hl_q <= prod_hl;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= cur_x_q;
      out_y_q    <= cur_y_q;
      out_z_q    <= cur_z_q;
      out_step_q <= slrw_pkg::STEP_W'(step_q);
      out_skip_q <= skip_q;
      out_last_q <= fin;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pos_x_o      = out_x_q;
  assign pos_y_o      = out_y_q;
  assign pos_z_o      = out_z_q;
  assign step_index_o = out_step_q;
  assign skipped_o    = out_skip_q;
  assign last_o       = out_last_q;

endmodule

@@ hw/rtl/splitmix_lattice_random_walk_core.sv @@
// Lattice random walk core. A request (origin, seed) enters on the input
// channel and yields one result per walk position on the output channel.
// Both channels use valid/stall; a transaction completes on a clock edge
// with valid high and stall low.
// Config is a write port (cfg_we_i, cfg_idx_i, cfg_wdata_i): min_height,
// max_height, walk_length. The user must write it only while the core is
// idle; the core itself does not enforce this. A rejected request (height
// outside the window or zero length) gives one result with skipped and
// last set. A request's first result goes from the queue through the
// walker's emit state into the output register; each further move runs
// the mixer through one shared set of three 32x32 partial-product
// multipliers twice, then folds the value to its residue mod 6. The
// walker takes the next request from the queue only when a walk is done.
// A two-entry request queue sits between intake and walker, so two more
// requests are taken while a walk runs; in_stall_o rises when it is full.
// When the receiver stalls, the result holds in the output register and
// the walker waits. Reset clears the queue, walker and output valid and
// loads the default config.
// depends on slrw_pkg, slrw_front, slrw_fifo and slrw_walker
module splitmix_lattice_random_walk_core #(
  parameter int MAX_WALK    = slrw_pkg::MAX_WALK_DEF,
  parameter int QUEUE_DEPTH = slrw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [slrw_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [slrw_pkg::CFG_DAT_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [slrw_pkg::COORD_W-1:0]  origin_x_i,
  input  logic signed [slrw_pkg::COORD_W-1:0]  origin_y_i,
  input  logic signed [slrw_pkg::COORD_W-1:0]  origin_z_i,
  input  logic [slrw_pkg::SEED_W-1:0]          walk_seed_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [slrw_pkg::COORD_W-1:0]  pos_x_o,
  output logic signed [slrw_pkg::COORD_W-1:0]  pos_y_o,
  output logic signed [slrw_pkg::COORD_W-1:0]  pos_z_o,
  output logic [slrw_pkg::STEP_W-1:0]          step_index_o,
  output logic                                 skipped_o,
  output logic                                 last_o
);

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  slrw_pkg::walk_req_t q_wdata;
  slrw_pkg::walk_req_t q_rdata;

  // intake and classification
  slrw_front #(
    .MAX_WALK(MAX_WALK)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .origin_x_i  (origin_x_i),
    .origin_y_i  (origin_y_i),
    .origin_z_i  (origin_z_i),
    .walk_seed_i (walk_seed_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .req_o       (q_wdata)
  );

  // request queue
  slrw_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  // walk sequencer
  slrw_walker #(
    .MAX_WALK(MAX_WALK)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .req_i        (q_rdata),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .pos_z_o      (pos_z_o),
    .step_index_o (step_index_o),
    .skipped_o    (skipped_o),
    .last_o       (last_o)
  );

endmodule

@@ hw/rtl/slrw_checker.sv @@
// port-level checks of the lattice random walk core, bound to the top level
// depends on splitmix_lattice_random_walk_core_macros.svh
`include "splitmix_lattice_random_walk_core_macros.svh"

module slrw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] pos_x_o,
  input logic [31:0] pos_y_o,
  input logic [31:0] pos_z_o,
  input logic [5:0]  step_index_o,
  input logic        skipped_o,
  input logic        last_o
);

  // a stalled result stays offered
  `SLRW_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // a stalled result keeps its payload
  `SLRW_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    $stable(pos_x_o) && $stable(pos_y_o) && $stable(pos_z_o) &&
    $stable(step_index_o) && $stable(skipped_o) && $stable(last_o))

  // a rejected request is a single result at step zero
  `SLRW_ASSERT_SAME(a_skip_single, clk_i, rst_ni, out_valid_o && skipped_o,
    last_o && (step_index_o == 6'd0))

endmodule

bind splitmix_lattice_random_walk_core slrw_checker u_slrw_checker (.*);
